[sv/psrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package psrc_pkg;

  // Table geometry: one entry per protocol and port.
  localparam int PortBits      = 16;
  localparam int TableAddrBits = PortBits + 1;
  localparam int TableSize     = 2 ** TableAddrBits;

  // Capture limits.
  localparam int SnapLen = 1024;
  localparam int PosBits = 11;
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  localparam logic [4:0] LinkOffsetReset = 5'd14;

  // Item kinds.
  localparam logic [1:0] FUNC_FRAME    = 2'd0;
  localparam logic [1:0] FUNC_REGISTER = 2'd1;
  localparam logic [1:0] FUNC_EXPIRE   = 2'd2;
  localparam logic [1:0] FUNC_READ     = 2'd3;

  // Port states.
  localparam logic [2:0] ST_ABSENT   = 3'd0;
  localparam logic [2:0] ST_PENDING  = 3'd1;
  localparam logic [2:0] ST_OPEN     = 3'd2;
  localparam logic [2:0] ST_CLOSED   = 3'd3;
  localparam logic [2:0] ST_FILTERED = 3'd4;

  // Header constants.
  localparam logic [7:0] PROTO_ICMP     = 8'd1;
  localparam logic [7:0] PROTO_TCP      = 8'd6;
  localparam logic [7:0] FLAG_SYN       = 8'h02;
  localparam logic [7:0] FLAG_RST       = 8'h04;
  localparam logic [7:0] FLAG_ACK       = 8'h10;
  localparam logic [7:0] ICMP_UNREACH   = 8'd3;
  localparam logic [5:0] MinIpHeaderLen = 6'd20;

endpackage

`default_nettype wire

[sv/port_scan_reply_classifier.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Word
// in        input      in_valid / in_ready       func, is_udp, port_number, packet_byte, last_byte
// out       output     out_valid / out_ready     out_is_udp, out_port, port_state, changed
// cfg       input      cfg_write (no wait)       cfg_data -> link_offset
//
// A frame byte that is not the last of its frame is taken in S_IDLE, and the block stays
// ready. Register, expire and read issue the table read on acceptance; the entry is modified
// and written back in S_RMW once the output is free, through the table memory. The last
// byte of a frame passes through S_FIN, and then S_RMW when its headers call for a lookup.
// After reset a clearing pass writes every one of the 131072 entries, one per cycle,
// before the first word is accepted. A stalled output holds the block in its write-back.

module port_scan_reply_classifier (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic        is_udp,
  input  wire logic [15:0] port_number,
  input  wire logic [7:0]  packet_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_is_udp,
  output logic [15:0]      out_port,
  output logic [2:0]       port_state,
  output logic             changed,
  input  wire logic        cfg_write,
  input  wire logic [4:0]  cfg_data
);

  localparam int AW = psrc_pkg::TableAddrBits;
  localparam int PW = psrc_pkg::PosBits;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_FIN   = 4'b0100,
    S_RMW   = 4'b1000
  } state_t;

  state_t state;

  logic [4:0]    link_offset;
  logic [AW-1:0] clr_addr;

  // Frame parse state.
  logic [PW-1:0] frame_position;
  logic [7:0]    ip_proto;
  logic [5:0]    outer_header_len;
  logic [5:0]    inner_header_len;
  logic [15:0]   captured_port;
  logic [7:0]    captured_flags;
  logic [1:0]    icmp_match;

  // The operation waiting for its table read.
  logic [1:0]  op_func;
  logic [2:0]  op_new;
  logic        op_udp;
  logic [15:0] op_port;
  logic        op_fit;

  // Table memory.
  logic [2:0]    port_mem [psrc_pkg::TableSize];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [2:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [2:0]    mem_rdata;

  logic          accept;
  logic [PW-1:0] lo;
  logic [PW-1:0] t_pos;
  logic [PW-1:0] u_pos;
  logic [PW-1:0] ui_pos;
  logic [PW:0]   cnt;
  logic          in_fit;
  logic          fin_hit;
  logic          fin_udp;
  logic [2:0]    fin_state;
  logic          out_free;
  logic [2:0]    rmw_new;
  logic          rmw_result;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign lo     = PW'(link_offset);
  assign t_pos  = lo + PW'(outer_header_len);
  assign u_pos  = t_pos + PW'(8);
  assign ui_pos = u_pos + PW'(inner_header_len);
  assign in_fit = (32'(port_number) >> psrc_pkg::PortBits) == 32'd0;

  // Decision at the end of a frame, from the fully parsed header fields.
  always_comb begin
    fin_hit   = 1'b0;
    fin_udp   = 1'b0;
    fin_state = psrc_pkg::ST_ABSENT;
    if ({1'b0, frame_position} > (PW + 1)'(psrc_pkg::SnapLen)) begin
      cnt = (PW + 1)'(psrc_pkg::SnapLen);
    end else begin
      cnt = {1'b0, frame_position};
    end
    if (outer_header_len >= psrc_pkg::MinIpHeaderLen) begin
      if (ip_proto == psrc_pkg::PROTO_TCP && cnt >= (PW + 1)'(t_pos) + (PW + 1)'(14)) begin
        if ((captured_flags & (psrc_pkg::FLAG_SYN | psrc_pkg::FLAG_ACK)) ==
            (psrc_pkg::FLAG_SYN | psrc_pkg::FLAG_ACK)) begin
          fin_hit   = 1'b1;
          fin_state = psrc_pkg::ST_OPEN;
        end else if ((captured_flags & psrc_pkg::FLAG_RST) != 8'd0) begin
          fin_hit   = 1'b1;
          fin_state = psrc_pkg::ST_CLOSED;
        end
      end else if (ip_proto == psrc_pkg::PROTO_ICMP && icmp_match == 2'b11 &&
                   cnt >= (PW + 1)'(ui_pos) + (PW + 1)'(4)) begin
        fin_hit   = 1'b1;
        fin_udp   = 1'b1;
        fin_state = psrc_pkg::ST_CLOSED;
      end
    end
  end

  // Read address: table items on acceptance, frame replies at frame end.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = {1'b0, captured_port[psrc_pkg::PortBits-1:0]};
    if (accept && func != psrc_pkg::FUNC_FRAME) begin
      mem_re    = 1'b1;
      mem_raddr = {is_udp, port_number[psrc_pkg::PortBits-1:0]};
    end else if (state == S_FIN && fin_hit) begin
      mem_re    = 1'b1;
      mem_raddr = {fin_udp, captured_port[psrc_pkg::PortBits-1:0]};
    end
  end

  // Entry update.
  always_comb begin
    rmw_new    = mem_rdata;
    rmw_result = 1'b1;
    unique case (op_func)
      psrc_pkg::FUNC_REGISTER: rmw_new = psrc_pkg::ST_PENDING;
      psrc_pkg::FUNC_EXPIRE: begin
        if (mem_rdata == psrc_pkg::ST_PENDING) begin
          rmw_new = op_udp ? psrc_pkg::ST_OPEN : psrc_pkg::ST_FILTERED;
        end
      end
      psrc_pkg::FUNC_READ: rmw_new = mem_rdata;
      default: begin
        // Replies only touch entries that are already present.
        rmw_new    = op_new;
        rmw_result = (mem_rdata != psrc_pkg::ST_ABSENT);
      end
    endcase
    if (!op_fit) begin
      rmw_new    = psrc_pkg::ST_ABSENT;
      rmw_result = (op_func != psrc_pkg::FUNC_FRAME);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {op_udp, op_port[psrc_pkg::PortBits-1:0]};
    mem_wdata = rmw_new;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = psrc_pkg::ST_ABSENT;
    end else if (state == S_RMW && out_free && op_fit && rmw_result) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      port_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= port_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_offset <= psrc_pkg::LinkOffsetReset;
    end else if (cfg_write) begin
      link_offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_addr         <= '0;
      frame_position   <= '0;
      ip_proto         <= '0;
      outer_header_len <= '0;
      inner_header_len <= '0;
      captured_port    <= '0;
      captured_flags   <= '0;
      icmp_match       <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (state == S_RMW && out_free && rmw_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(psrc_pkg::TableSize - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (func == psrc_pkg::FUNC_FRAME) begin
              if ({1'b0, frame_position} < (PW + 1)'(psrc_pkg::SnapLen)) begin
                if (frame_position == lo) begin
                  outer_header_len <= {packet_byte[3:0], 2'b00};
                end else if (frame_position == lo + PW'(9)) begin
                  ip_proto <= packet_byte;
                end else if (outer_header_len >= psrc_pkg::MinIpHeaderLen &&
                             frame_position >= lo) begin
                  if (ip_proto == psrc_pkg::PROTO_TCP) begin
                    if (frame_position == t_pos) begin
                      captured_port <= {packet_byte, 8'h00};
                    end else if (frame_position == t_pos + PW'(1)) begin
                      captured_port[7:0] <= packet_byte;
                    end else if (frame_position == t_pos + PW'(13)) begin
                      captured_flags <= packet_byte;
                    end
                  end else if (ip_proto == psrc_pkg::PROTO_ICMP) begin
                    if (frame_position == t_pos) begin
                      icmp_match[0] <= (packet_byte == psrc_pkg::ICMP_UNREACH);
                    end else if (frame_position == t_pos + PW'(1)) begin
                      icmp_match[1] <= (packet_byte == psrc_pkg::ICMP_UNREACH);
                    end else if (frame_position == u_pos) begin
                      inner_header_len <= {packet_byte[3:0], 2'b00};
                    end else if (frame_position == ui_pos + PW'(2)) begin
                      captured_port <= {packet_byte, 8'h00};
                    end else if (frame_position == ui_pos + PW'(3)) begin
                      captured_port[7:0] <= packet_byte;
                    end
                  end
                end
              end
              if (frame_position != psrc_pkg::PosMax) begin
                frame_position <= frame_position + PW'(1);
              end
              if (last_byte) begin
                state <= S_FIN;
              end
            end else begin
              state <= S_RMW;
            end
          end
        end
        S_FIN: begin
          // The frame is done either way; its parse state starts over.
          frame_position   <= '0;
          ip_proto         <= '0;
          outer_header_len <= '0;
          inner_header_len <= '0;
          captured_port    <= '0;
          captured_flags   <= '0;
          icmp_match       <= '0;
          state            <= fin_hit ? S_RMW : S_IDLE;
        end
        S_RMW: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operation and result words; no reset needed.
  always_ff @(posedge clk) begin
    if (accept && func != psrc_pkg::FUNC_FRAME) begin
      op_func <= func;
      op_udp  <= is_udp;
      op_port <= port_number;
      op_fit  <= in_fit;
      op_new  <= psrc_pkg::ST_ABSENT;
    end else if (state == S_FIN) begin
      op_func <= psrc_pkg::FUNC_FRAME;
      op_udp  <= fin_udp;
      op_port <= captured_port;
      op_fit  <= (32'(captured_port) >> psrc_pkg::PortBits) == 32'd0;
      op_new  <= fin_state;
    end
    if (state == S_RMW && out_free && rmw_result) begin
      out_is_udp <= op_udp;
      out_port   <= op_port;
      port_state <= rmw_new;
      changed    <= op_fit && (rmw_new != mem_rdata);
    end
  end

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import psrc_pkg::*;

  localparam int CycleLimit    = 2_000_000;
  localparam int CfgSettle     = 6;
  localparam int EndSettle     = 8;
  localparam int OpsPerPhase   = 8;
  localparam int FrameBufLen   = 2112;
  localparam int LongFrameLen  = 2100;
  localparam int IpProtoOfs    = 9;
  localparam int TcpFlagsOfs   = 13;
  localparam int TcpHdrLen     = 20;
  localparam int IcmpHdrLen    = 8;
  localparam int UdpHdrLen     = 8;
  localparam int UdpDstOfs     = 2;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {FR_TCP, FR_ICMP, FR_OTHER, FR_NOISE} frame_kind_t;
  typedef enum logic {ROW_OP, ROW_FRAME} row_kind_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        is_udp;
    logic [15:0] port;
    logic [7:0]  pbyte;
    logic        last;
  } word_t;

  typedef struct packed {
    logic        is_udp;
    logic [15:0] port;
    logic [2:0]  st;
    logic        chg;
  } reply_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [3:0]  ihl;
    logic [3:0]  inner_ihl;
    logic [7:0]  other_proto;
    logic [7:0]  flags;
    logic [7:0]  ctl_type;
    logic [7:0]  ctl_code;
    logic [15:0] port;
    int          cut;
    int          pad;
    bit          mixed;
  } frame_spec_t;

  typedef struct packed {
    row_kind_t   kind;
    word_t       w;
    bit          typed;
    reply_t      want;
    frame_spec_t f;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic        is_udp;
  logic [15:0] port_number;
  logic [7:0]  packet_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_udp;
  logic [15:0] out_port;
  logic [2:0]  port_state;
  logic        changed;
  logic        cfg_write;
  logic [4:0]  cfg_data;

  port_scan_reply_classifier dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .is_udp      (is_udp),
    .port_number (port_number),
    .packet_byte (packet_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_is_udp  (out_is_udp),
    .out_port    (out_port),
    .port_state  (port_state),
    .changed     (changed),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the port table and of the frame parser.
  logic [2:0]  port_tbl [TableSize];
  int          link_ofs;
  int          fpos;
  int          ip_hlen;
  int          inner_hlen;
  logic [7:0]  proto;
  logic [7:0]  tcp_flags;
  logic [15:0] cap_port;
  logic [1:0]  icmp_hit;

  reply_t      pending_replies [$];
  dir_row_t    dir_rows [$];
  logic [7:0]  frame_buf [FrameBufLen];
  int          frame_len;
  logic [15:0] port_pool [8];

  int          burst_left = 0;
  int          fail_count = 0;
  int          words_sent = 0;
  int          replies_seen = 0;
  int          frame_hits = 0;
  int          cfg_writes = 0;
  int          cycle_cnt = 0;
  int          rcv_left = 0;
  logic [1:0]  rcv_mode = 2'd0;

  function automatic void clear_parse();
    fpos       = 0;
    ip_hlen    = 0;
    inner_hlen = 0;
    proto      = 8'd0;
    tcp_flags  = 8'd0;
    cap_port   = 16'd0;
    icmp_hit   = 2'd0;
  endfunction

  function automatic void parse_byte(input int p, input logic [7:0] b);
    int t;
    int u;
    if (p >= SnapLen) return;
    if (p == link_ofs) begin
      ip_hlen = b[3:0] * 4;
      return;
    end
    if (p == link_ofs + IpProtoOfs) begin
      proto = b;
      return;
    end
    if (ip_hlen < MinIpHeaderLen || p < link_ofs) return;
    t = link_ofs + ip_hlen;
    if (proto == PROTO_TCP) begin
      if (p == t) cap_port = {b, 8'h00};
      else if (p == t + 1) cap_port[7:0] = b;
      else if (p == t + TcpFlagsOfs) tcp_flags = b;
    end else if (proto == PROTO_ICMP) begin
      u = t + IcmpHdrLen;
      if (p == t) icmp_hit[0] = (b == ICMP_UNREACH);
      else if (p == t + 1) icmp_hit[1] = (b == ICMP_UNREACH);
      else if (p == u) inner_hlen = b[3:0] * 4;
      else if (p == u + inner_hlen + UdpDstOfs) cap_port = {b, 8'h00};
      else if (p == u + inner_hlen + UdpDstOfs + 1) cap_port[7:0] = b;
    end
  endfunction

  // A reply only touches entries that are already present.
  function automatic bit mark_reply(input logic udp, input logic [15:0] p,
                                    input logic [2:0] st, output reply_t r);
    logic [2:0] prev;
    prev = port_tbl[{udp, p}];
    if (prev == ST_ABSENT) return 1'b0;
    port_tbl[{udp, p}] = st;
    r.is_udp = udp;
    r.port   = p;
    r.st     = st;
    r.chg    = (prev != st);
    return 1'b1;
  endfunction

  function automatic bit end_frame(output reply_t r);
    int cnt;
    int t;
    bit hit;
    hit = 1'b0;
    cnt = (fpos > SnapLen) ? SnapLen : fpos;
    if (ip_hlen >= MinIpHeaderLen) begin
      t = link_ofs + ip_hlen;
      if (proto == PROTO_TCP && cnt >= t + TcpFlagsOfs + 1) begin
        if ((tcp_flags & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK))
          hit = mark_reply(1'b0, cap_port, ST_OPEN, r);
        else if ((tcp_flags & FLAG_RST) != 8'd0)
          hit = mark_reply(1'b0, cap_port, ST_CLOSED, r);
      end else if (proto == PROTO_ICMP && icmp_hit == 2'b11 &&
                   cnt >= t + IcmpHdrLen + inner_hlen + UdpDstOfs + 2) begin
        hit = mark_reply(1'b1, cap_port, ST_CLOSED, r);
      end
    end
    clear_parse();
    return hit;
  endfunction

  function automatic bit classify_word(input word_t w, output reply_t r);
    logic [2:0] prev;
    logic [2:0] nxt;
    if (w.func == FUNC_FRAME) begin
      parse_byte(fpos, w.pbyte);
      if (fpos < PosMax) fpos++;
      if (w.last) return end_frame(r);
      return 1'b0;
    end
    prev = port_tbl[{w.is_udp, w.port}];
    nxt  = prev;
    if (w.func == FUNC_REGISTER) nxt = ST_PENDING;
    else if (w.func == FUNC_EXPIRE && prev == ST_PENDING)
      nxt = w.is_udp ? ST_OPEN : ST_FILTERED;
    port_tbl[{w.is_udp, w.port}] = nxt;
    r.is_udp = w.is_udp;
    r.port   = w.port;
    r.st     = nxt;
    r.chg    = (nxt != prev);
    return 1'b1;
  endfunction

  // Lays out a frame at the current link offset. Only the bytes the parser
  // looks at are placed; everything else is random.
  function automatic void build_frame(input frame_spec_t s);
    int t;
    int u;
    int full;
    t = link_ofs + ((s.ihl >= 4'd5) ? s.ihl * 4 : 20);
    u = t + IcmpHdrLen;
    case (s.kind)
      FR_TCP:  full = t + TcpHdrLen;
      FR_ICMP: full = u + s.inner_ihl * 4 + UdpHdrLen;
      FR_OTHER: full = t;
      default: full = 0;
    endcase
    full = full + s.pad;
    if (full > FrameBufLen) full = FrameBufLen;
    if (full < 1) full = 1;
    for (int i = 0; i < full; i++) frame_buf[i] = 8'($urandom);
    if (s.kind != FR_NOISE) begin
      frame_buf[link_ofs] = {4'h4, s.ihl};
      frame_buf[link_ofs + IpProtoOfs] = (s.kind == FR_TCP)  ? PROTO_TCP :
                                         (s.kind == FR_ICMP) ? PROTO_ICMP : s.other_proto;
    end
    if (s.kind == FR_TCP) begin
      frame_buf[t]               = s.port[15:8];
      frame_buf[t + 1]           = s.port[7:0];
      frame_buf[t + TcpFlagsOfs] = s.flags;
    end else if (s.kind == FR_ICMP) begin
      frame_buf[t]     = s.ctl_type;
      frame_buf[t + 1] = s.ctl_code;
      frame_buf[u]     = {4'h4, s.inner_ihl};
      frame_buf[u + s.inner_ihl * 4 + UdpDstOfs]     = s.port[15:8];
      frame_buf[u + s.inner_ihl * 4 + UdpDstOfs + 1] = s.port[7:0];
    end
    frame_len = (s.cut > 0 && s.cut < full) ? s.cut : full;
  endfunction

  function automatic frame_spec_t mk_frame(input frame_kind_t kind, input logic [3:0] ihl,
                                           input logic [3:0] inner, input logic [15:0] p,
                                           input logic [7:0] flags, input logic [7:0] code,
                                           input int cut, input int pad, input bit mixed);
    frame_spec_t s;
    s             = '0;
    s.kind        = kind;
    s.ihl         = ihl;
    s.inner_ihl   = inner;
    s.other_proto = PROTO_UDP;
    s.flags       = flags;
    s.ctl_type    = ICMP_UNREACH;
    s.ctl_code    = code;
    s.port        = p;
    s.cut         = cut;
    s.pad         = pad;
    s.mixed       = mixed;
    return s;
  endfunction

  function automatic logic [15:0] pick_port();
    return ($urandom_range(0, 9) < 8) ? port_pool[$urandom_range(0, 7)] : 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_code();
    return ($urandom_range(0, 9) < 8) ? ICMP_UNREACH : 8'($urandom);
  endfunction

  function automatic frame_spec_t rand_frame();
    frame_spec_t s;
    int k;
    s = '0;
    k = $urandom_range(0, 99);
    s.kind = (k < 50) ? FR_TCP : (k < 85) ? FR_ICMP : FR_OTHER;
    k = $urandom_range(0, 99);
    s.ihl = (k < 75) ? 4'd5 : (k < 90) ? 4'($urandom_range(6, 15)) : 4'($urandom_range(0, 4));
    s.inner_ihl = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom);
    s.other_proto = 8'($urandom);
    case ($urandom_range(0, 5))
      0, 1:    s.flags = FLAG_SYN | FLAG_ACK;
      2:       s.flags = FLAG_RST;
      3:       s.flags = FLAG_SYN;
      4:       s.flags = FLAG_ACK;
      default: s.flags = 8'($urandom);
    endcase
    // Extra flag bits that do not take part in the decision.
    if ($urandom_range(0, 1) == 1) s.flags = s.flags | (8'($urandom) & 8'hE9);
    s.ctl_type = pick_code();
    s.ctl_code = pick_code();
    s.port  = pick_port();
    s.cut   = ($urandom_range(0, 9) < 2) ? $urandom_range(1, link_ofs + 48) : 0;
    s.pad   = $urandom_range(0, 16);
    s.mixed = ($urandom_range(0, 9) == 0);
    return s;
  endfunction

  function automatic word_t pick_op_word(input bit from_pool);
    word_t w;
    w.func   = 2'($urandom_range(FUNC_REGISTER, FUNC_READ));
    w.is_udp = 1'($urandom);
    w.port   = from_pool ? pick_port() : 16'($urandom);
    w.pbyte  = 8'($urandom);
    w.last   = 1'($urandom);
    return w;
  endfunction

  function automatic dir_row_t op_row(input logic [1:0] f, input logic udp,
                                      input logic [15:0] p, input bit typed,
                                      input logic [2:0] st, input logic chg);
    dir_row_t d;
    d             = '0;
    d.kind        = ROW_OP;
    d.w.func      = f;
    d.w.is_udp    = udp;
    d.w.port      = p;
    d.w.pbyte     = 8'($urandom);
    d.w.last      = 1'($urandom);
    d.typed       = typed;
    d.want.is_udp = udp;
    d.want.port   = p;
    d.want.st     = st;
    d.want.chg    = chg;
    return d;
  endfunction

  function automatic dir_row_t frame_row(input frame_spec_t s);
    dir_row_t d;
    d      = '0;
    d.kind = ROW_FRAME;
    d.f    = s;
    return d;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_word(input word_t w, input bit typed, input reply_t want);
    reply_t r;
    bit hit;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid    <= 1'b1;
    func        <= w.func;
    is_udp      <= w.is_udp;
    port_number <= w.port;
    packet_byte <= w.pbyte;
    last_byte   <= w.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hit = classify_word(w, r);
    words_sent++;
    if (typed) pending_replies.push_back(want);
    else if (hit) pending_replies.push_back(r);
    if (hit && w.func == FUNC_FRAME) frame_hits++;
  endtask

  task automatic send_frame(input frame_spec_t s);
    word_t w;
    build_frame(s);
    for (int i = 0; i < frame_len; i++) begin
      if (s.mixed && $urandom_range(0, 5) == 0) send_word(pick_op_word(1'b1), 1'b0, '0);
      w.func   = FUNC_FRAME;
      w.is_udp = 1'($urandom);
      w.port   = 16'($urandom);
      w.pbyte  = frame_buf[i];
      w.last   = (i == frame_len - 1);
      send_word(w, 1'b0, '0);
    end
  endtask

  // Always moves at least one edge so that in_valid never gets two updates in one step.
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_link(input logic [4:0] v);
    drain(CfgSettle);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    link_ofs = v;
    cfg_writes++;
  endtask

  always @(posedge clk) begin
    if (rcv_left == 0) begin
      rcv_mode <= 2'($urandom_range(0, 2));
      rcv_left <= $urandom_range(16, 128);
    end else begin
      rcv_left <= rcv_left - 1;
    end
    case (rcv_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 99) < 60);
      default: out_ready <= (rcv_left[1:0] == 2'd0);
    endcase
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && out_valid && out_ready) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $error("unexpected word: port %0d state %0d", out_port, port_state);
        fail_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        check_field("out_is_udp", exp_r.is_udp, out_is_udp);
        check_field("out_port", exp_r.port, out_port);
        check_field("port_state", exp_r.st, port_state);
        check_field("changed", exp_r.chg, changed);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [4:0] phase_ofs [5];
    int k;
    int ops;
    rst         = 1'b1;
    in_valid    = 1'b0;
    func        = FUNC_READ;
    is_udp      = 1'b0;
    port_number = 16'd0;
    packet_byte = 8'd0;
    last_byte   = 1'b0;
    cfg_write   = 1'b0;
    cfg_data    = 5'd0;

    for (int i = 0; i < TableSize; i++) port_tbl[i] = ST_ABSENT;
    link_ofs = LinkOffsetReset;
    clear_parse();
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) port_pool[i] = 16'($urandom);

    // Directed rows, built at the reset link offset.
    dir_rows.push_back(op_row(FUNC_READ, 1'b0, 16'h0000, 1, ST_ABSENT, 1'b0));
    dir_rows.push_back(op_row(FUNC_READ, 1'b1, 16'hFFFF, 1, ST_ABSENT, 1'b0));
    dir_rows.push_back(op_row(FUNC_EXPIRE, 1'b0, 16'h0000, 1, ST_ABSENT, 1'b0));
    dir_rows.push_back(op_row(FUNC_REGISTER, 1'b0, 16'h0000, 1, ST_PENDING, 1'b1));
    dir_rows.push_back(op_row(FUNC_REGISTER, 1'b0, 16'h0000, 1, ST_PENDING, 1'b0));
    dir_rows.push_back(op_row(FUNC_REGISTER, 1'b1, 16'hFFFF, 1, ST_PENDING, 1'b1));
    dir_rows.push_back(op_row(FUNC_REGISTER, 1'b0, 16'hFFFF, 1, ST_PENDING, 1'b1));
    dir_rows.push_back(op_row(FUNC_REGISTER, 1'b1, 16'h0000, 1, ST_PENDING, 1'b1));
    dir_rows.push_back(frame_row(mk_frame(FR_TCP, 4'd5, 4'd5, 16'h0000,
                                          FLAG_SYN | FLAG_ACK, ICMP_UNREACH, 0, 0, 0)));
    dir_rows.push_back(frame_row(mk_frame(FR_TCP, 4'd5, 4'd5, 16'hFFFF,
                                          FLAG_RST, ICMP_UNREACH, 0, 0, 0)));
    dir_rows.push_back(frame_row(mk_frame(FR_ICMP, 4'd5, 4'd5, 16'hFFFF,
                                          8'h00, ICMP_UNREACH, 0, 0, 0)));
    // An open port registered again goes back to pending.
    dir_rows.push_back(op_row(FUNC_REGISTER, 1'b0, 16'h0000, 1, ST_PENDING, 1'b1));
    dir_rows.push_back(op_row(FUNC_EXPIRE, 1'b0, 16'h0000, 1, ST_FILTERED, 1'b1));
    dir_rows.push_back(op_row(FUNC_EXPIRE, 1'b0, 16'h0000, 1, ST_FILTERED, 1'b0));
    dir_rows.push_back(op_row(FUNC_EXPIRE, 1'b1, 16'h0000, 1, ST_OPEN, 1'b1));
    // A late reset still closes a filtered port.
    dir_rows.push_back(frame_row(mk_frame(FR_TCP, 4'd5, 4'd5, 16'h0000,
                                          FLAG_RST, ICMP_UNREACH, 0, 0, 0)));
    dir_rows.push_back(frame_row(mk_frame(FR_TCP, 4'd5, 4'd5, 16'd1234,
                                          FLAG_SYN | FLAG_ACK, ICMP_UNREACH, 0, 0, 0)));
    // Ends one byte before the flags byte.
    dir_rows.push_back(frame_row(mk_frame(FR_TCP, 4'd5, 4'd5, 16'hFFFF, FLAG_SYN | FLAG_ACK,
                                          ICMP_UNREACH, link_ofs + 20 + TcpFlagsOfs, 0, 0)));
    dir_rows.push_back(frame_row(mk_frame(FR_TCP, 4'd4, 4'd5, 16'hFFFF,
                                          FLAG_SYN | FLAG_ACK, ICMP_UNREACH, 0, 0, 0)));
    dir_rows.push_back(frame_row(mk_frame(FR_OTHER, 4'd5, 4'd5, 16'hFFFF,
                                          FLAG_RST, ICMP_UNREACH, 0, 24, 0)));
    dir_rows.push_back(frame_row(mk_frame(FR_ICMP, 4'd5, 4'd5, 16'hFFFF,
                                          8'h00, 8'd1, 0, 0, 0)));
    dir_rows.push_back(frame_row(mk_frame(FR_ICMP, 4'd5, 4'd6, 16'h0000,
                                          8'h00, ICMP_UNREACH, 0, 4, 1)));
    // Runs past the capture length and the position counter's top.
    dir_rows.push_back(frame_row(mk_frame(FR_TCP, 4'd5, 4'd5, 16'hFFFF, FLAG_SYN | FLAG_ACK,
                                          ICMP_UNREACH, 0,
                                          LongFrameLen - (link_ofs + 20 + TcpHdrLen), 0)));
    dir_rows.push_back(frame_row(mk_frame(FR_TCP, 4'd5, 4'd5, 16'hFFFF,
                                          FLAG_ACK, ICMP_UNREACH, 0, 0, 0)));
    dir_rows.push_back(op_row(FUNC_READ, 1'b1, 16'h0000, 0, ST_ABSENT, 1'b0));

    phase_ofs[0] = 5'd0;
    phase_ofs[1] = 5'd31;
    phase_ofs[2] = 5'd4;
    phase_ofs[3] = 5'd16;
    phase_ofs[4] = 5'($urandom_range(1, 30));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_OP) send_word(dir_rows[i].w, dir_rows[i].typed,
                                                dir_rows[i].want);
      else send_frame(dir_rows[i].f);
    end

    for (int ph = 0; ph < 5; ph++) begin
      set_link(phase_ofs[ph]);
      for (int i = 2; i < 8; i++) port_pool[i] = 16'($urandom);
      ops = 0;
      while (ops < OpsPerPhase) begin
        k = $urandom_range(0, 99);
        if (k < 45) send_frame(rand_frame());
        else if (k < 85) send_word(pick_op_word(1'b1), 1'b0, '0);
        else if (k < 92) send_word(pick_op_word(1'b0), 1'b0, '0);
        else if (k < 99) send_frame(mk_frame(FR_NOISE, 4'd5, 4'd5, 16'h0000, 8'h00,
                                             ICMP_UNREACH, 0, $urandom_range(1, 80), 0));
        else drain(0);
        ops++;
      end
    end

    drain(EndSettle);
    $display("Sent %0d words over %0d link offsets; %0d results checked, %0d from frames.",
             words_sent, cfg_writes + 1, replies_seen, frame_hits);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
